[src/tcpoa_pkg.sv]
// ----------------------------------------------------------------------------
// tcpoa_pkg
// Shared types, codes and helpers for the TCP option address extractor.
// ----------------------------------------------------------------------------
package tcpoa_pkg;

  // Largest option area a TCP header can carry
  localparam int unsigned DEF_MAX_OPTION_BYTES = 40;

  // Option kinds with a fixed meaning
  localparam logic [7:0] KIND_EOL = 8'd0;
  localparam logic [7:0] KIND_NOP = 8'd1;
  // Smallest legal kind/length option (kind byte plus length byte)
  localparam logic [7:0] MIN_OPTION_SIZE = 8'd2;

  // found_type codes
  localparam logic [1:0] FT_NONE = 2'd0;
  localparam logic [1:0] FT_V4   = 2'd1;
  localparam logic [1:0] FT_V6   = 2'd2;

  // ip_family codes
  localparam logic [1:0] FAM_V4 = 2'd0;
  localparam logic [1:0] FAM_V6 = 2'd1;

  // Register reset values
  localparam logic [7:0] RST_V4_KIND = 8'd254;
  localparam logic [5:0] RST_V4_SIZE = 6'd8;
  localparam logic [7:0] RST_V6_KIND = 8'd253;
  localparam logic [5:0] RST_V6_SIZE = 6'd20;

  typedef enum logic [1:0] {
    CFG_V4_KIND = 2'd0,
    CFG_V4_SIZE = 2'd1,
    CFG_V6_KIND = 2'd2,
    CFG_V6_SIZE = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_KIND,
    PH_SIZE,
    PH_BODY,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic [7:0] v4_kind;
    logic [5:0] v4_size;
    logic [7:0] v6_kind;
    logic [5:0] v6_size;
  } cfg_t;

  typedef struct packed {
    logic [7:0] option_byte;
    logic       first_byte;
    logic       last_byte;
    logic [5:0] area_length;
    logic [1:0] ip_family;
  } item_t;

  typedef struct packed {
    logic [1:0]  found_type;
    logic [31:0] client_ipv4;
    logic [63:0] client_ipv6_high;
    logic [63:0] client_ipv6_low;
  } result_t;

  // IPv6 meaning wins when both kinds and sizes agree
  function automatic logic [1:0] option_match(logic [1:0] fam, logic [7:0] kind,
                                              logic [5:0] size, cfg_t cfg);
    logic [1:0] m;
    m = FT_NONE;
    if (fam == FAM_V6 && kind == cfg.v6_kind && size == cfg.v6_size) begin
      m = FT_V6;
    end else if ((fam == FAM_V4 || fam == FAM_V6) && kind == cfg.v4_kind &&
                 size == cfg.v4_size) begin
      m = FT_V4;
    end
    return m;
  endfunction

endpackage

[src/tcpoa_cfg.sv]
// ----------------------------------------------------------------------------
// tcpoa_cfg
// Configuration registers: option kinds and sizes of the address options.
// ----------------------------------------------------------------------------
module tcpoa_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  output tcpoa_pkg::cfg_t   cfg_o
);
  import tcpoa_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_V4_KIND: cfg_d.v4_kind = cfg_data_i;
        CFG_V4_SIZE: cfg_d.v4_size = cfg_data_i[5:0];
        CFG_V6_KIND: cfg_d.v6_kind = cfg_data_i;
        CFG_V6_SIZE: cfg_d.v6_size = cfg_data_i[5:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.v4_kind <= RST_V4_KIND;
      cfg_q.v4_size <= RST_V4_SIZE;
      cfg_q.v6_kind <= RST_V6_KIND;
      cfg_q.v6_size <= RST_V6_SIZE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/tcpoa_parser.sv]
// ----------------------------------------------------------------------------
// tcpoa_parser
// Option walker: per-byte state update and verdict for one registered byte.
// ----------------------------------------------------------------------------
module tcpoa_parser #(
  parameter int unsigned MAX_OPTION_BYTES = tcpoa_pkg::DEF_MAX_OPTION_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,     // process item_i this cycle
  input  tcpoa_pkg::item_t   item_i,
  input  tcpoa_pkg::cfg_t    cfg_i,
  output logic               emit_o,     // verdict on this step
  output tcpoa_pkg::result_t result_o
);
  import tcpoa_pkg::*;

  localparam logic [5:0] MaxBytes = 6'(MAX_OPTION_BYTES);

  phase_e      phase_q, phase_d;
  logic [5:0]  left_q, left_d;
  logic [7:0]  kind_q, kind_d;
  logic [5:0]  size_q, size_d;
  logic [5:0]  bio_q, bio_d;
  logic [1:0]  fam_q, fam_d;
  logic [63:0] hi_q, hi_d, lo_q, lo_d;
  logic        emit;
  logic [1:0]  vtype;
  logic [1:0]  m;
  logic [7:0]  b;

  assign b = item_i.option_byte;

  // Next state and verdict
  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    kind_d  = kind_q;
    size_d  = size_q;
    bio_d   = bio_q;
    fam_d   = fam_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    emit    = 1'b0;
    vtype   = FT_NONE;
    m       = FT_NONE;

    if (item_i.first_byte) begin
      left_d  = (item_i.area_length > MaxBytes) ? MaxBytes : item_i.area_length;
      fam_d   = item_i.ip_family;
      phase_d = PH_KIND;
      kind_d  = '0;
      size_d  = '0;
      bio_d   = '0;
      hi_d    = '0;
      lo_d    = '0;
    end

    if (item_i.first_byte || phase_q != PH_DONE) begin
      if (left_d == '0) begin
        emit = 1'b1;
      end else begin
        case (phase_d)
          PH_KIND: begin
            left_d = left_d - 6'd1;
            if (b == KIND_EOL) begin
              emit = 1'b1;
            end else if (b != KIND_NOP) begin
              if (left_d == '0) begin
                emit = 1'b1;
              end else begin
                kind_d  = b;
                phase_d = PH_SIZE;
              end
            end
          end
          PH_SIZE: begin
            if (b < MIN_OPTION_SIZE || b > ({2'b00, left_d} + 8'd1)) begin
              emit = 1'b1;
            end else begin
              left_d = left_d - 6'd1;
              size_d = b[5:0];
              bio_d  = b[5:0] - 6'd2;
              hi_d   = '0;
              lo_d   = '0;
              if (bio_d == '0) begin
                phase_d = PH_KIND;
                m = option_match(fam_d, kind_d, size_d, cfg_i);
                if (m != FT_NONE) begin
                  emit  = 1'b1;
                  vtype = m;
                end
              end else begin
                phase_d = PH_BODY;
              end
            end
          end
          PH_BODY: begin
            hi_d   = {hi_d[55:0], lo_d[63:56]};
            lo_d   = {lo_d[55:0], b};
            left_d = left_d - 6'd1;
            bio_d  = bio_d - 6'd1;
            if (bio_d == '0) begin
              phase_d = PH_KIND;
              m = option_match(fam_d, kind_d, size_d, cfg_i);
              if (m != FT_NONE) begin
                emit  = 1'b1;
                vtype = m;
              end
            end
          end
          default: emit = 1'b1;
        endcase
        if (!emit && ((phase_d == PH_KIND && left_d == '0) || item_i.last_byte)) begin
          emit = 1'b1;
        end
      end
      if (emit) begin
        phase_d = PH_DONE;
      end
    end
  end

  // Verdict fields: an address that does not belong to the type reads as zero
  always_comb begin
    emit_o                    = emit;
    result_o.found_type       = vtype;
    result_o.client_ipv4      = (vtype == FT_V4) ? lo_d[31:0] : '0;
    result_o.client_ipv6_high = (vtype == FT_V6) ? hi_d : '0;
    result_o.client_ipv6_low  = (vtype == FT_V6) ? lo_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_KIND;
      left_q  <= '0;
      fam_q   <= FAM_V4;
    end else if (step_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      fam_q   <= fam_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      kind_q <= kind_d;
      size_q <= size_d;
      bio_q  <= bio_d;
      hi_q   <= hi_d;
      lo_q   <= lo_d;
    end
  end

  a_done_after_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && emit |=> phase_q == PH_DONE)
    else $error("parser not parked after verdict");

  a_v6_only_for_v6: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && emit && vtype == FT_V6 |-> fam_d == FAM_V6)
    else $error("IPv6 verdict for a non-IPv6 packet");

  a_stray_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_DONE && !item_i.first_byte |-> !emit)
    else $error("verdict on a byte after the packet's verdict");

  a_left_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= MaxBytes)
    else $error("remaining byte count above area maximum");

endmodule

[src/tcp_option_address_extractor.sv]
// ----------------------------------------------------------------------------
// tcp_option_address_extractor
// Walks TCP option bytes and reports the client address option, one verdict
// per packet.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  --------  ---------  ----------------------  --------------------------------
//  in        sink       in_valid_i / in_ready_o option_byte, first/last_byte,
//                                               area_length, ip_family
//  out       source     out_valid_o/out_ready_i found_type, client_ipv4,
//                                               client_ipv6_high/low
//  cfg       sink       cfg_we_i (no wait)      cfg_index_i, cfg_data_i
//
//  One byte per clock while the result register drains. A byte is held in the
//  input register; the parser updates its state and, on the deciding byte,
//  loads the result register, from which the verdict is shown.
//  The only stall path is a full result register with out_ready_i low; bytes
//  that give no verdict still wait behind it to keep verdicts in order.
//  Reset (rst_ni, async low) empties both registers and restores the option
//  kinds and sizes to their defaults; no clearing pass is needed.
//
module tcp_option_address_extractor #(
  parameter int unsigned MAX_OPTION_BYTES = tcpoa_pkg::DEF_MAX_OPTION_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // option byte stream
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  option_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  input  logic [5:0]  area_length_i,
  input  logic [1:0]  ip_family_i,
  // verdicts
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  found_type_o,
  output logic [31:0] client_ipv4_o,
  output logic [63:0] client_ipv6_high_o,
  output logic [63:0] client_ipv6_low_o,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import tcpoa_pkg::*;

  cfg_t    cfg;
  item_t   in_q, in_d;
  logic    in_valid_q, in_valid_d;
  result_t out_q, step_res;
  logic    out_valid_q, out_valid_d;
  logic    step;      // input register hands its byte to the parser
  logic    step_emit;

  tcpoa_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Byte moves on whenever the result register is free or being drained.
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_comb begin
    in_d.option_byte = option_byte_i;
    in_d.first_byte  = first_byte_i;
    in_d.last_byte   = last_byte_i;
    in_d.area_length = area_length_i;
    in_d.ip_family   = ip_family_i;
    in_valid_d       = in_valid_i || (in_valid_q && !step);
  end

  tcpoa_parser #(
    .MAX_OPTION_BYTES (MAX_OPTION_BYTES)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .emit_o   (step_emit),
    .result_o (step_res)
  );

  assign out_valid_d = (step && step_emit) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_d;
    end
    if (step && step_emit) begin
      out_q <= step_res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign found_type_o       = out_q.found_type;
  assign client_ipv4_o      = out_q.client_ipv4;
  assign client_ipv6_high_o = out_q.client_ipv6_high;
  assign client_ipv6_low_o  = out_q.client_ipv6_low;

  a_verdict_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && step_emit |=> out_valid_q)
    else $error("verdict dropped on its way to the result register");

  a_none_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_type_o == FT_NONE |->
      client_ipv4_o == '0 && client_ipv6_high_o == '0 && client_ipv6_low_o == '0)
    else $error("address bits set on a no-address verdict");

  a_v4_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_type_o == FT_V4 |->
      client_ipv6_high_o == '0 && client_ipv6_low_o == '0)
    else $error("IPv6 bits set on an IPv4 verdict");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !step)
    else $error("parser stepped while a verdict is still pending");

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tcp_option_address_extractor. A directed table
// covers the corner cases of the option walk, then randomized option areas
// (mostly well-formed kind/length lists, some noise and broken ones) run
// through several register settings with bursty input and a stalling sink.
// Each verdict is compared against a cycle-free model of the option parser or a typed-in verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tcpoa_pkg::*;

  localparam int MAX_AREA       = DEF_MAX_OPTION_BYTES;
  localparam int RANDOM_ITEMS   = 1300;
  localparam int PHASE_ITEMS    = 160;
  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
  localparam int DRAIN_LIMIT    = 1000;  // below the watchdog on purpose
  localparam int SETTLE_CYCLES  = 8;     // slack after the last verdict

  // ip_family values outside the two real families
  localparam logic [1:0] FAM_OTHER    = 2'd2;
  localparam logic [1:0] FAM_RESERVED = 2'd3;

  // Sink ready patterns
  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_mode_e;

  // One register setting, raw 8-bit write data (sizes lose their top bits)
  typedef struct packed {
    logic [7:0] v4_kind;
    logic [7:0] v4_size;
    logic [7:0] v6_kind;
    logic [7:0] v6_size;
  } reg_plan_t;

  // Directed row: the byte, and a typed-in verdict where one is obvious
  typedef struct packed {
    item_t   stim;
    logic    typed;
    result_t want;
  } dir_row_t;

  localparam result_t VERDICT_NONE = '{FT_NONE, 32'h0, 64'h0, 64'h0};

  localparam int DIRECTED_ROWS = 24;
  localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
    // stray byte straight out of reset: no area loaded, verdict none
    '{'{8'hAA, 1'b0, 1'b0, 6'd63, FAM_RESERVED}, 1'b1, VERDICT_NONE},
    // one-byte packet, both marks, area saturated; kind 255 cut off by last
    '{'{8'hFF, 1'b1, 1'b1, 6'd63, FAM_V6}, 1'b1, VERDICT_NONE},
    // zero area length decides on the first byte
    '{'{8'h55, 1'b1, 1'b0, 6'd0, FAM_V4}, 1'b1, VERDICT_NONE},
    // byte after the verdict without first mark: dropped
    '{'{8'h12, 1'b0, 1'b1, 6'd5, FAM_RESERVED}, 1'b0, VERDICT_NONE},
    // end of list
    '{'{KIND_EOL, 1'b1, 1'b0, 6'd40, FAM_V4}, 1'b1, VERDICT_NONE},
    // NOP, then the default IPv4 address option; address in the last 4 bytes
    '{'{KIND_NOP, 1'b1, 1'b0, 6'd9, FAM_V4}, 1'b0, VERDICT_NONE},
    '{'{RST_V4_KIND, 1'b0, 1'b0, 6'd0, FAM_OTHER}, 1'b0, VERDICT_NONE},
    '{'{8'(RST_V4_SIZE), 1'b0, 1'b0, 6'd63, FAM_RESERVED}, 1'b0, VERDICT_NONE},
    '{'{8'h11, 1'b0, 1'b0, 6'd21, FAM_V6}, 1'b0, VERDICT_NONE},
    '{'{8'h22, 1'b0, 1'b0, 6'd42, FAM_OTHER}, 1'b0, VERDICT_NONE},
    '{'{8'hC0, 1'b0, 1'b0, 6'd0, FAM_V4}, 1'b0, VERDICT_NONE},
    '{'{8'hA8, 1'b0, 1'b0, 6'd7, FAM_V6}, 1'b0, VERDICT_NONE},
    '{'{8'h01, 1'b0, 1'b0, 6'd56, FAM_RESERVED}, 1'b0, VERDICT_NONE},
    '{'{8'h02, 1'b0, 1'b1, 6'd63, FAM_V4}, 1'b1,
      '{FT_V4, 32'hC0A8_0102, 64'h0, 64'h0}},
    // size below the minimum
    '{'{8'h05, 1'b1, 1'b0, 6'd4, FAM_V6}, 1'b0, VERDICT_NONE},
    '{'{8'h01, 1'b0, 1'b0, 6'd0, FAM_V4}, 1'b1, VERDICT_NONE},
    // size runs past the end of the area
    '{'{8'h05, 1'b1, 1'b0, 6'd3, FAM_V4}, 1'b0, VERDICT_NONE},
    '{'{8'h04, 1'b0, 1'b0, 6'd63, FAM_V6}, 1'b1, VERDICT_NONE},
    // real kind on the final area byte
    '{'{KIND_NOP, 1'b1, 1'b0, 6'd2, FAM_V6}, 1'b0, VERDICT_NONE},
    '{'{8'h07, 1'b0, 1'b0, 6'd1, FAM_OTHER}, 1'b1, VERDICT_NONE},
    // last mark arrives mid-option
    '{'{8'h09, 1'b1, 1'b0, 6'd10, FAM_V4}, 1'b0, VERDICT_NONE},
    '{'{8'h06, 1'b0, 1'b0, 6'd32, FAM_V6}, 1'b0, VERDICT_NONE},
    '{'{8'h33, 1'b0, 1'b0, 6'd16, FAM_RESERVED}, 1'b0, VERDICT_NONE},
    '{'{8'h44, 1'b0, 1'b1, 6'd8, FAM_OTHER}, 1'b1, VERDICT_NONE}
  };

  // Fixed register settings for the random phases after the first one
  localparam int PLAN_ROWS = 6;
  localparam reg_plan_t REG_PLAN [PLAN_ROWS] = '{
    '{8'd255, 8'd40, 8'd0, 8'd2},     // extremes; v6 kind collides with EOL
    '{8'd0, 8'd2, 8'd255, 8'd40},     // mirrored extremes
    '{8'd30, 8'd2, 8'd31, 8'd6},      // short options: leading address zeros
    '{8'd77, 8'd10, 8'd77, 8'd10},    // identical options, IPv6 must win
    '{KIND_NOP, 8'd8, KIND_NOP, 8'd20},  // NOP kinds never match
    '{8'd200, 8'hC8, 8'd100, 8'hFF}   // top bits of the sizes dropped
  };

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni = 1'b0;

  logic        in_valid    = 1'b0;
  logic [7:0]  option_byte = '0;
  logic        first_byte  = 1'b0;
  logic        last_byte   = 1'b0;
  logic [5:0]  area_length = '0;
  logic [1:0]  ip_family   = '0;
  logic        out_ready   = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [1:0]  cfg_index   = '0;
  logic [7:0]  cfg_data    = '0;

  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  found_type_o;
  logic [31:0] client_ipv4_o;
  logic [63:0] client_ipv6_high_o;
  logic [63:0] client_ipv6_low_o;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  tcp_option_address_extractor dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .option_byte_i      (option_byte),
    .first_byte_i       (first_byte),
    .last_byte_i        (last_byte),
    .area_length_i      (area_length),
    .ip_family_i        (ip_family),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .found_type_o       (found_type_o),
    .client_ipv4_o      (client_ipv4_o),
    .client_ipv6_high_o (client_ipv6_high_o),
    .client_ipv6_low_o  (client_ipv6_low_o),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Option parser model: registers, walk state, expected verdicts
  // --------------------------------------------------------------------------
  logic [7:0]  reg_v4_kind, reg_v6_kind;
  logic [5:0]  reg_v4_size, reg_v6_size;

  phase_e      parse_ph   = PH_KIND;
  logic [5:0]  opt_left   = '0;   // area bytes not yet consumed
  logic [7:0]  cur_kind   = '0;
  logic [5:0]  cur_size   = '0;
  logic [5:0]  body_left  = '0;   // body bytes still to come in this option
  logic [1:0]  pkt_family = '0;
  logic [63:0] addr_hi    = '0;
  logic [63:0] addr_lo    = '0;
  logic        decided    = 1'b0;

  result_t     verdicts_due [$];
  int          fail_count = 0;
  int          items_sent = 0;

  // Which address option, if any, the option just closed is
  function automatic logic [1:0] address_option_hit();
    if (pkt_family == FAM_V6 && cur_kind == reg_v6_kind && cur_size == reg_v6_size)
      return FT_V6;
    if ((pkt_family == FAM_V4 || pkt_family == FAM_V6) &&
        cur_kind == reg_v4_kind && cur_size == reg_v4_size)
      return FT_V4;
    return FT_NONE;
  endfunction

  // Form the verdict for the packet and stop walking it
  function automatic bit close_packet(input logic [1:0] ft, output result_t v);
    v.found_type       = ft;
    v.client_ipv4      = (ft == FT_V4) ? addr_lo[31:0] : 32'h0;
    v.client_ipv6_high = (ft == FT_V6) ? addr_hi : 64'h0;
    v.client_ipv6_low  = (ft == FT_V6) ? addr_lo : 64'h0;
    decided  = 1'b1;
    parse_ph = PH_DONE;
    return 1'b1;
  endfunction

  // Advance the walk by one byte; returns 1 when the byte decides the packet
  function automatic bit walk_option_byte(input item_t it, output result_t v);
    logic [1:0] hit;
    v = VERDICT_NONE;
    if (it.first_byte) begin
      opt_left   = (it.area_length > MAX_AREA) ? 6'(MAX_AREA) : it.area_length;
      pkt_family = it.ip_family;
      decided    = 1'b0;
      parse_ph   = PH_KIND;
      cur_kind   = '0;
      cur_size   = '0;
      body_left  = '0;
      addr_hi    = '0;
      addr_lo    = '0;
    end else if (decided || parse_ph == PH_DONE) begin
      return 1'b0;
    end

    if (opt_left == 0) return close_packet(FT_NONE, v);

    case (parse_ph)
      PH_KIND: begin
        opt_left = opt_left - 6'd1;
        if (it.option_byte == KIND_EOL) return close_packet(FT_NONE, v);
        if (it.option_byte != KIND_NOP) begin
          // a real kind needs at least its size byte inside the area
          if (opt_left == 0) return close_packet(FT_NONE, v);
          cur_kind = it.option_byte;
          parse_ph = PH_SIZE;
        end
      end
      PH_SIZE: begin
        if (it.option_byte < MIN_OPTION_SIZE ||
            it.option_byte > ({2'b00, opt_left} + 8'd1))
          return close_packet(FT_NONE, v);
        opt_left  = opt_left - 6'd1;
        cur_size  = it.option_byte[5:0];
        body_left = it.option_byte[5:0] - 6'd2;
        addr_hi   = '0;
        addr_lo   = '0;
        if (body_left == 0) begin
          parse_ph = PH_KIND;
          hit = address_option_hit();
          if (hit != FT_NONE) return close_packet(hit, v);
        end else begin
          parse_ph = PH_BODY;
        end
      end
      default: begin
        // trailing body bytes shift through a 128-bit window
        addr_hi   = {addr_hi[55:0], addr_lo[63:56]};
        addr_lo   = {addr_lo[55:0], it.option_byte};
        opt_left  = opt_left - 6'd1;
        body_left = body_left - 6'd1;
        if (body_left == 0) begin
          parse_ph = PH_KIND;
          hit = address_option_hit();
          if (hit != FT_NONE) return close_packet(hit, v);
        end
      end
    endcase

    if ((parse_ph == PH_KIND && opt_left == 0) || it.last_byte)
      return close_packet(FT_NONE, v);
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: bursts of random length separated by random gaps
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_max    = 3;

  // Present one byte, hold it until the transaction completes, then predict
  task automatic issue_byte(input item_t it, input bit typed, input result_t want);
    result_t predicted;
    int      gap;
    in_valid    <= 1'b1;
    option_byte <= it.option_byte;
    first_byte  <= it.first_byte;
    last_byte   <= it.last_byte;
    area_length <= it.area_length;
    ip_family   <= it.ip_family;
    do @(posedge clk_i); while (!in_ready_o);

    // bytes after a verdict are dropped by the block; do not count them
    if (it.first_byte || !decided) items_sent++;
    if (walk_option_byte(it, predicted))
      verdicts_due.push_back(typed ? want : predicted);

    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Random option bytes for one kind/length option (size may be malformed)
  logic [7:0] area_bytes [$];

  task automatic add_option(input logic [7:0] kind, input int size);
    area_bytes.push_back(kind);
    area_bytes.push_back(size[7:0]);
    for (int k = 2; k < size; k++) area_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Let every expected verdict arrive, then let the pipeline empty
  task automatic wait_for_verdicts();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write; the model follows at the same moment since nothing is in
  // flight when this runs
  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_V4_KIND: reg_v4_kind = data;
      CFG_V4_SIZE: reg_v4_size = data[5:0];
      CFG_V6_KIND: reg_v6_kind = data;
      default:     reg_v6_size = data[5:0];
    endcase
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Output side: sink stalls on a pattern chosen per phase
  // --------------------------------------------------------------------------
  rx_mode_e rx_mode = RX_RANDOM;
  int       rx_tick = 0;
  int       rx_hold = 0;

  always @(posedge clk_i) begin
    case (rx_mode)
      RX_ALWAYS:   out_ready <= 1'b1;
      RX_RANDOM:   out_ready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: begin
        rx_tick = (rx_tick + 1) % 7;
        out_ready <= (rx_tick >= 3);
      end
      default: begin
        // long runs of ready and not-ready, each of random length
        if (rx_hold == 0) begin
          rx_hold = $urandom_range(1, 12);
          out_ready <= !out_ready;
        end else begin
          rx_hold = rx_hold - 1;
        end
      end
    endcase
  end

  // Verdict checker: oldest expectation first, field by field
  always @(posedge clk_i) begin
    result_t exp_v;
    if (out_valid_o && out_ready) begin
      if (verdicts_due.size() == 0) begin
        $error("unexpected verdict: found_type %0d", found_type_o);
        fail_count++;
      end else begin
        exp_v = verdicts_due.pop_front();
        if (found_type_o !== exp_v.found_type) begin
          $error("found_type: expected %0d, got %0d", exp_v.found_type, found_type_o);
          fail_count++;
        end
        if (client_ipv4_o !== exp_v.client_ipv4) begin
          $error("client_ipv4: expected %h, got %h", exp_v.client_ipv4, client_ipv4_o);
          fail_count++;
        end
        if (client_ipv6_high_o !== exp_v.client_ipv6_high) begin
          $error("client_ipv6_high: expected %h, got %h",
                 exp_v.client_ipv6_high, client_ipv6_high_o);
          fail_count++;
        end
        if (client_ipv6_low_o !== exp_v.client_ipv6_low) begin
          $error("client_ipv6_low: expected %h, got %h",
                 exp_v.client_ipv6_low, client_ipv6_low_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long without a transaction on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("tcp_option_address_extractor verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    reg_plan_t  plan;
    item_t      it;
    logic [5:0] len_field;
    logic [1:0] fam;
    bit         mark_last;
    int         phase, phase_end, eff, stream_len, r, n;

    reg_v4_kind = RST_V4_KIND;
    reg_v4_size = RST_V4_SIZE;
    reg_v6_kind = RST_V6_KIND;
    reg_v6_size = RST_V6_SIZE;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corner cases, under the reset register values
    foreach (DIRECTED[row])
      issue_byte(DIRECTED[row].stim, DIRECTED[row].typed, DIRECTED[row].want);

    // Random phases: phase 0 keeps the reset registers, later ones reprogram
    phase = 0;
    while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
      if (phase > 0) begin
        wait_for_verdicts();
        if (phase <= PLAN_ROWS) begin
          plan = REG_PLAN[phase - 1];
        end else begin
          plan.v4_kind = 8'($urandom_range(0, 255));
          plan.v6_kind = 8'($urandom_range(0, 255));
          plan.v4_size = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(2, 40));
          plan.v6_size = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(2, 40));
        end
        write_reg(CFG_V4_KIND, plan.v4_kind);
        write_reg(CFG_V4_SIZE, plan.v4_size);
        write_reg(CFG_V6_KIND, plan.v6_kind);
        write_reg(CFG_V6_SIZE, plan.v6_size);
        cfg_we <= 1'b0;
      end

      // gap_max 0 gives a phase of back-to-back bytes
      gap_max = 3 * $urandom_range(0, 2);
      rx_mode <= rx_mode_e'($urandom_range(0, 3));

      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
        // occasional stray bytes between packets
        if ($urandom_range(0, 19) == 0) begin
          n = $urandom_range(1, 2);
          repeat (n) begin
            it.option_byte = 8'($urandom_range(0, 255));
            it.first_byte  = 1'b0;
            it.last_byte   = 1'($urandom_range(0, 1));
            it.area_length = 6'($urandom_range(0, 63));
            it.ip_family   = 2'($urandom_range(0, 3));
            issue_byte(it, 1'b0, VERDICT_NONE);
          end
        end

        // area length: mostly short, some full-size, zero and saturating ones
        r = $urandom_range(0, 99);
        if (r < 4)       len_field = 6'd0;
        else if (r < 8)  len_field = 6'($urandom_range(MAX_AREA + 1, 63));
        else if (r < 12) len_field = 6'd1;
        else if (r < 27) len_field = 6'($urandom_range(25, MAX_AREA));
        else             len_field = 6'($urandom_range(2, 24));
        eff = (int'(len_field) > MAX_AREA) ? MAX_AREA : int'(len_field);

        r = $urandom_range(0, 9);
        fam = (r < 4) ? FAM_V4 : (r < 8) ? FAM_V6 : (r < 9) ? FAM_OTHER : FAM_RESERVED;

        // option list: mostly well-formed, biased toward the address options
        area_bytes.delete();
        while (area_bytes.size() < eff) begin
          r = $urandom_range(0, 99);
          if (r < 20)      area_bytes.push_back(KIND_NOP);
          else if (r < 42) add_option(reg_v4_kind, int'(reg_v4_size));
          else if (r < 64) add_option(reg_v6_kind, int'(reg_v6_size));
          else if (r < 72) add_option($urandom_range(0, 1) ? reg_v4_kind : reg_v6_kind,
                                      $urandom_range(0, 12));
          else if (r < 90) add_option(8'($urandom_range(2, 255)), $urandom_range(2, 8));
          else if (r < 94) area_bytes.push_back(KIND_EOL);
          else             area_bytes.push_back(8'($urandom_range(0, 255)));
        end
        while (area_bytes.size() > eff) void'(area_bytes.pop_back());

        // stream length: usually the area, sometimes cut short or overlong
        mark_last = 1'b1;
        r = $urandom_range(0, 9);
        if (eff == 0) begin
          stream_len = $urandom_range(1, 2);
        end else if (r == 0) begin
          stream_len = $urandom_range(1, eff);
          mark_last  = 1'($urandom_range(0, 1));
        end else if (r == 1) begin
          stream_len = eff + $urandom_range(1, 3);
        end else begin
          stream_len = eff;
        end

        for (int i = 0; i < stream_len; i++) begin
          it.option_byte = (i < area_bytes.size()) ? area_bytes[i]
                                                   : 8'($urandom_range(0, 255));
          it.first_byte  = (i == 0);
          it.last_byte   = mark_last && (i == stream_len - 1);
          // length and family only matter on the first byte
          it.area_length = (i == 0) ? len_field : 6'($urandom_range(0, 63));
          it.ip_family   = (i == 0) ? fam : 2'($urandom_range(0, 3));
          issue_byte(it, 1'b0, VERDICT_NONE);
        end
      end
      phase++;
    end

    wait_for_verdicts();
    if (verdicts_due.size() != 0) begin
      $error("%0d expected verdicts never arrived", verdicts_due.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("tcp_option_address_extractor verification clean");
    end else begin
      $display("tcp_option_address_extractor verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/tcpoa_pkg.sv
src/tcpoa_cfg.sv
src/tcpoa_parser.sv
src/tcp_option_address_extractor.sv
sim/testbench.sv
